// ----- rtl/dphy_pll_divider_search_assert.svh -----
// Assertion macros shared by the divider search RTL.
`ifndef DPHY_PLL_DIVIDER_SEARCH_ASSERT_SVH
`define DPHY_PLL_DIVIDER_SEARCH_ASSERT_SVH

// The consequent must hold at every edge at which the antecedent holds.
`define DPDS_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The expression must never be true at a clock edge.
`define DPDS_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error(msg);

`endif

// ----- rtl/dpds_pkg.sv -----
// Types, constants and the band table of the D-PHY PLL divider search.
`timescale 1ns / 1ps

package dpds_pkg;

   localparam int PIXEL_W     = 20;
   localparam int BPP_W       = 6;
   localparam int LANES_W     = 3;
   localparam int LANE_RATE_W = 26;
   localparam int VCO_W       = 6;
   localparam int M_W         = 10;
   localparam int N_W         = 4;
   localparam int STATUS_W    = 2;

   localparam int PROD_W      = 26;   // pixel_khz * bits_per_pixel
   localparam int PHY_FULL_W  = 25;   // lane rate halved, before the range check
   localparam int PHY_W       = 21;   // PHY clock once inside the legal range
   localparam int SCALE_W     = 31;   // scaled PHY clock times 1000
   localparam int TARGET_W    = 26;
   localparam int QT_W        = 6;    // target / 1e6
   localparam int CAND_W      = 10;   // rounded feedback divider
   localparam int BACK_W      = 30;   // candidate times 1e6
   localparam int BEST_W      = 27;
   localparam int DIVIDEND_W  = 32;
   localparam int DIVISOR_W   = 20;
   localparam int PAIR_W      = 5;

   localparam int PAIRS_PROD   = (PROD_W + 1) / 2;
   localparam int PAIRS_SCALE  = (SCALE_W + 1) / 2;
   localparam int PAIRS_TARGET = (TARGET_W + 1) / 2;
   localparam int PAIRS_BACK   = (BACK_W + 1) / 2;
   localparam int SHIFT_PROD   = DIVIDEND_W - 2 * PAIRS_PROD;
   localparam int SHIFT_SCALE  = DIVIDEND_W - 2 * PAIRS_SCALE;
   localparam int SHIFT_TARGET = DIVIDEND_W - 2 * PAIRS_TARGET;
   localparam int SHIFT_BACK   = DIVIDEND_W - 2 * PAIRS_BACK;

   localparam int unsigned PHY_MIN_KHZ  = 40000;
   localparam int unsigned PHY_MAX_KHZ  = 1250000;
   localparam int unsigned REF_MHZ      = 24;
   localparam int unsigned KHZ_PER_MHZ  = 1000;
   localparam int unsigned ROUND_HALF   = 500000;
   localparam int unsigned SCALE_ONE    = 1000000;
   localparam int unsigned INITIAL_BEST = 100000000;

   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_DIV = 2'd2;

   localparam int NUM_BANDS = 10;

   // Exclusive upper limit of each band; the last band has none.
   localparam logic [PHY_W-1:0] BAND_LIMIT [NUM_BANDS-1] = '{
      21'd55000, 21'd82500, 21'd110000, 21'd165000, 21'd220000,
      21'd330000, 21'd440000, 21'd660000, 21'd1149000
   };
   localparam logic [VCO_W-1:0] BAND_CODE [NUM_BANDS] = '{
      6'h3f, 6'h37, 6'h2f, 6'h27, 6'h1f, 6'h17, 6'h0f, 6'h09, 6'h03, 6'h01
   };

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_khz;
      logic [BPP_W-1:0]   bits_per_pixel;
      logic [LANES_W-1:0] lane_count;
   } req_type;

   typedef struct packed {
      logic [LANE_RATE_W-1:0] lane_rate;
      logic [VCO_W-1:0]       vco_code;
      logic [M_W-1:0]         m_field;
      logic [N_W-1:0]         n_field;
      logic [STATUS_W-1:0]    status;
   } rsp_type;

   typedef struct packed {
      logic [PROD_W-1:0]  prod;
      logic [LANES_W-1:0] lanes;
      logic               zero_lanes;
   } job_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
      logic [PAIR_W-1:0]     pairs;
   } div_cmd_type;

   typedef struct packed {
      logic                  busy;
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
      logic [DIVISOR_W-1:0]  remainder;
   } div_rsp_type;

   // First band whose limit lies above the PHY clock.
   function automatic logic [VCO_W-1:0] band_code(input logic [PHY_W-1:0] phy);
      logic [VCO_W-1:0] code;
      begin
         code = BAND_CODE[NUM_BANDS-1];
         for (int k = NUM_BANDS - 2; k >= 0; k--) begin
            if (phy < BAND_LIMIT[k]) begin
               code = BAND_CODE[k];
            end
         end
         return code;
      end
   endfunction

endpackage

// ----- rtl/dpds_fifo.sv -----
// Small first-in first-out queue with the head item shown ahead.
`timescale 1ns / 1ps

module dpds_fifo #(
   parameter type item_type = logic,
   parameter int  DEPTH     = 2
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output item_type pop_item,
   output logic     empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type           slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- rtl/dpds_front.sv -----
// Front stage: takes request beats, forms the pixel product and flags zero lanes.
`timescale 1ns / 1ps

module dpds_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  dpds_pkg::req_type req_item,
   output logic              full,
   output logic              job_push,
   output dpds_pkg::job_type job_item,
   input  logic              job_full
);

   import dpds_pkg::*;

   logic    stage_valid_ff, stage_valid_in;
   req_type stage_ff, stage_in;
   logic    accept;

   assign full     = stage_valid_ff && job_full;
   assign accept   = push && !full;
   assign job_push = stage_valid_ff && !job_full;

   always_comb begin
      job_item.prod       = PROD_W'(stage_ff.pixel_khz) * PROD_W'(stage_ff.bits_per_pixel);
      job_item.lanes      = stage_ff.lane_count;
      job_item.zero_lanes = (stage_ff.lane_count == '0);
   end

   always_comb begin
      stage_valid_in = accept || (stage_valid_ff && !job_push);
      stage_in       = accept ? req_item : stage_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      stage_ff <= stage_in;
   end

endmodule

// ----- rtl/dpds_divider.sv -----
// Shared restoring divider, two quotient bits per cycle.
`timescale 1ns / 1ps

module dpds_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  dpds_pkg::div_cmd_type cmd,
   output dpds_pkg::div_rsp_type rsp
);

   import dpds_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [PAIR_W-1:0]     pairs_ff, pairs_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  divisor_ff, divisor_in;

   logic [DIVISOR_W:0]    rem_a, rem_b;
   logic                  ge_a, ge_b;
   logic [DIVISOR_W-1:0]  rem_1, rem_2;
   logic [DIVIDEND_W-1:0] quo_1, quo_2;

   // The dividend shifts out at the top while quotient bits enter at the bottom.
   always_comb begin
      rem_a = {rem_ff, quo_ff[DIVIDEND_W-1]};
      ge_a  = (rem_a >= {1'b0, divisor_ff});
      rem_1 = ge_a ? DIVISOR_W'(rem_a - {1'b0, divisor_ff}) : rem_a[DIVISOR_W-1:0];
      quo_1 = {quo_ff[DIVIDEND_W-2:0], ge_a};
      rem_b = {rem_1, quo_1[DIVIDEND_W-1]};
      ge_b  = (rem_b >= {1'b0, divisor_ff});
      rem_2 = ge_b ? DIVISOR_W'(rem_b - {1'b0, divisor_ff}) : rem_b[DIVISOR_W-1:0];
      quo_2 = {quo_1[DIVIDEND_W-2:0], ge_b};
   end

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      pairs_in   = pairs_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (cmd.start) begin
         busy_in    = 1'b1;
         pairs_in   = cmd.pairs;
         rem_in     = '0;
         quo_in     = cmd.dividend;
         divisor_in = cmd.divisor;
      end else if (busy_ff) begin
         rem_in   = rem_2;
         quo_in   = quo_2;
         pairs_in = pairs_ff - 1'b1;
         if (pairs_ff == PAIR_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      pairs_ff   <= pairs_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign rsp.busy      = busy_ff;
   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

endmodule

// ----- rtl/dpds_back.sv -----
// Back end sequencer: lane rate, band choice and the input divider search.
`timescale 1ns / 1ps

module dpds_back #(
   parameter int MAX_INPUT_DIVIDER    = 16,
   parameter int MAX_FEEDBACK_DIVIDER = 625
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  job_empty,
   input  dpds_pkg::job_type     job_item,
   output logic                  job_pop,
   output dpds_pkg::div_cmd_type div_cmd,
   input  dpds_pkg::div_rsp_type div_rsp,
   output logic                  rsp_push,
   output dpds_pkg::rsp_type     rsp_item,
   input  logic                  rsp_full
);

   import dpds_pkg::*;

   localparam int IDX_W = $clog2(MAX_INPUT_DIVIDER + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LANE,
      ST_SCALE,
      ST_TARGET,
      ST_SPLIT,
      ST_STEP,
      ST_BACK,
      ST_OUT
   } state_type;

   state_type             state_ff, state_in;
   logic                  div_start_ff, div_start_in;
   logic [DIVIDEND_W-1:0] div_dividend_ff, div_dividend_in;
   logic [DIVISOR_W-1:0]  div_divisor_ff, div_divisor_in;
   logic [PAIR_W-1:0]     div_pairs_ff, div_pairs_in;
   logic [LANE_RATE_W-1:0] lane_rate_ff, lane_rate_in;
   logic [PHY_W-1:0]      phy_ff, phy_in;
   logic [VCO_W-1:0]      vco_ff, vco_in;
   logic [TARGET_W-1:0]   target_ff, target_in;
   logic [QT_W-1:0]       qt_ff, qt_in;
   logic [DIVISOR_W-1:0]  rt_ff, rt_in;
   logic [CAND_W-1:0]     acc_q_ff, acc_q_in;
   logic [DIVISOR_W-1:0]  acc_r_ff, acc_r_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [CAND_W-1:0]     cand_ff, cand_in;
   logic [BEST_W-1:0]     best_ff, best_in;
   logic [IDX_W-1:0]      best_n_ff, best_n_in;
   logic [CAND_W-1:0]     best_m_ff, best_m_in;
   rsp_type               rsp_item_ff, rsp_item_in;

   logic [PHY_FULL_W-1:0] phy_full;
   logic [SCALE_W-1:0]    scaled, scale_prod;
   logic [DIVISOR_W:0]    sum_r;
   logic                  carry;
   logic [DIVISOR_W-1:0]  next_r;
   logic [CAND_W-1:0]     next_q;
   logic [IDX_W-1:0]      next_idx;
   logic [BACK_W-1:0]     back_num, back_q, target_ext, err;

   function automatic rsp_type make_result(
      input logic [LANE_RATE_W-1:0] lane,
      input logic [VCO_W-1:0]       vco,
      input logic [IDX_W-1:0]       n,
      input logic [CAND_W-1:0]      m
   );
      rsp_type          r;
      logic [IDX_W-1:0] n_less;
      logic [CAND_W-1:0] m_less;
      begin
         n_less     = n - 1'b1;
         m_less     = m - CAND_W'(2);
         r.lane_rate = lane;
         r.vco_code  = vco;
         if (n == '0) begin
            r.m_field = '0;
            r.n_field = '0;
            r.status  = STATUS_NO_DIV;
         end else begin
            r.m_field = M_W'(m_less);
            r.n_field = N_W'(n_less);
            r.status  = STATUS_OK;
         end
         return r;
      end
   endfunction

   always_comb begin
      phy_full   = div_rsp.quotient[LANE_RATE_W-1:1];
      scaled     = SCALE_W'(phy_ff) << vco_ff[VCO_W-1:VCO_W-2];
      scale_prod = scaled * SCALE_W'(KHZ_PER_MHZ);
      // Numerator target * i + 500000 kept as quotient and remainder by 1e6.
      sum_r      = {1'b0, acc_r_ff} + {1'b0, rt_ff};
      carry      = (sum_r >= (DIVISOR_W + 1)'(SCALE_ONE));
      next_r     = carry ? DIVISOR_W'(sum_r - (DIVISOR_W + 1)'(SCALE_ONE))
                         : sum_r[DIVISOR_W-1:0];
      next_q     = acc_q_ff + CAND_W'(qt_ff) + CAND_W'(carry);
      next_idx   = idx_ff + 1'b1;
      back_num   = BACK_W'(next_q) * BACK_W'(SCALE_ONE);
      back_q     = div_rsp.quotient[BACK_W-1:0];
      target_ext = BACK_W'(target_ff);
      err        = (target_ext > back_q) ? target_ext - back_q : back_q - target_ext;
   end

   always_comb begin
      state_in        = state_ff;
      div_start_in    = 1'b0;
      div_dividend_in = div_dividend_ff;
      div_divisor_in  = div_divisor_ff;
      div_pairs_in    = div_pairs_ff;
      lane_rate_in    = lane_rate_ff;
      phy_in          = phy_ff;
      vco_in          = vco_ff;
      target_in       = target_ff;
      qt_in           = qt_ff;
      rt_in           = rt_ff;
      acc_q_in        = acc_q_ff;
      acc_r_in        = acc_r_ff;
      idx_in          = idx_ff;
      cand_in         = cand_ff;
      best_in         = best_ff;
      best_n_in       = best_n_ff;
      best_m_in       = best_m_ff;
      rsp_item_in     = rsp_item_ff;
      job_pop         = 1'b0;
      rsp_push        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!job_empty) begin
               job_pop = 1'b1;
               if (job_item.zero_lanes) begin
                  rsp_item_in        = '0;
                  rsp_item_in.status = STATUS_RANGE;
                  state_in           = ST_OUT;
               end else begin
                  div_start_in    = 1'b1;
                  div_dividend_in = DIVIDEND_W'(job_item.prod) << SHIFT_PROD;
                  div_divisor_in  = DIVISOR_W'(job_item.lanes);
                  div_pairs_in    = PAIR_W'(PAIRS_PROD);
                  state_in        = ST_LANE;
               end
            end
         end
         ST_LANE: begin
            if (div_rsp.done) begin
               lane_rate_in = div_rsp.quotient[LANE_RATE_W-1:0];
               if ((phy_full > PHY_FULL_W'(PHY_MAX_KHZ)) ||
                   (phy_full < PHY_FULL_W'(PHY_MIN_KHZ))) begin
                  rsp_item_in           = '0;
                  rsp_item_in.lane_rate = div_rsp.quotient[LANE_RATE_W-1:0];
                  rsp_item_in.status    = STATUS_RANGE;
                  state_in              = ST_OUT;
               end else begin
                  phy_in   = phy_full[PHY_W-1:0];
                  vco_in   = band_code(phy_full[PHY_W-1:0]);
                  state_in = ST_SCALE;
               end
            end
         end
         ST_SCALE: begin
            div_start_in    = 1'b1;
            div_dividend_in = DIVIDEND_W'(scale_prod) << SHIFT_SCALE;
            div_divisor_in  = DIVISOR_W'(REF_MHZ);
            div_pairs_in    = PAIR_W'(PAIRS_SCALE);
            state_in        = ST_TARGET;
         end
         ST_TARGET: begin
            if (div_rsp.done) begin
               target_in       = div_rsp.quotient[TARGET_W-1:0];
               div_start_in    = 1'b1;
               div_dividend_in = DIVIDEND_W'(div_rsp.quotient[TARGET_W-1:0]) << SHIFT_TARGET;
               div_divisor_in  = DIVISOR_W'(SCALE_ONE);
               div_pairs_in    = PAIR_W'(PAIRS_TARGET);
               state_in        = ST_SPLIT;
            end
         end
         ST_SPLIT: begin
            if (div_rsp.done) begin
               qt_in     = div_rsp.quotient[QT_W-1:0];
               rt_in     = div_rsp.remainder;
               acc_q_in  = '0;
               acc_r_in  = DIVISOR_W'(ROUND_HALF);
               idx_in    = '0;
               best_in   = BEST_W'(INITIAL_BEST);
               best_n_in = '0;
               best_m_in = '0;
               state_in  = ST_STEP;
            end
         end
         ST_STEP: begin
            if (idx_ff == IDX_W'(MAX_INPUT_DIVIDER)) begin
               rsp_item_in = make_result(lane_rate_ff, vco_ff, best_n_ff, best_m_ff);
               state_in    = ST_OUT;
            end else begin
               idx_in   = next_idx;
               acc_q_in = next_q;
               acc_r_in = next_r;
               // A candidate above the feedback limit is passed over.
               if (next_q <= CAND_W'(MAX_FEEDBACK_DIVIDER)) begin
                  cand_in         = next_q;
                  div_start_in    = 1'b1;
                  div_dividend_in = DIVIDEND_W'(back_num) << SHIFT_BACK;
                  div_divisor_in  = DIVISOR_W'(next_idx);
                  div_pairs_in    = PAIR_W'(PAIRS_BACK);
                  state_in        = ST_BACK;
               end
            end
         end
         ST_BACK: begin
            if (div_rsp.done) begin
               state_in = ST_STEP;
               if (BACK_W'(best_ff) > err) begin
                  best_in   = err[BEST_W-1:0];
                  best_n_in = idx_ff;
                  best_m_in = cand_ff;
                  if (err == '0) begin
                     rsp_item_in = make_result(lane_rate_ff, vco_ff, idx_ff, cand_ff);
                     state_in    = ST_OUT;
                  end
               end
            end
         end
         ST_OUT: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         div_start_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_start_ff <= div_start_in;
      end
      div_dividend_ff <= div_dividend_in;
      div_divisor_ff  <= div_divisor_in;
      div_pairs_ff    <= div_pairs_in;
      lane_rate_ff    <= lane_rate_in;
      phy_ff          <= phy_in;
      vco_ff          <= vco_in;
      target_ff       <= target_in;
      qt_ff           <= qt_in;
      rt_ff           <= rt_in;
      acc_q_ff        <= acc_q_in;
      acc_r_ff        <= acc_r_in;
      idx_ff          <= idx_in;
      cand_ff         <= cand_in;
      best_ff         <= best_in;
      best_n_ff       <= best_n_in;
      best_m_ff       <= best_m_in;
      rsp_item_ff     <= rsp_item_in;
   end

   assign div_cmd.start    = div_start_ff;
   assign div_cmd.dividend = div_dividend_ff;
   assign div_cmd.divisor  = div_divisor_ff;
   assign div_cmd.pairs    = div_pairs_ff;
   assign rsp_item         = rsp_item_ff;

endmodule

// ----- rtl/dphy_pll_divider_search.sv -----
// Top level of the D-PHY PLL divider search.
//
// The block is used as a pair of queues. A request beat (pixel clock in kHz,
// bits per pixel, lane count) is taken at a rising edge with push high and
// full low. Each request gives exactly one result beat, in request order; the
// oldest result sits on rsp_item while empty is low and leaves at an edge with
// pop high and empty low.
// The front stage forms the pixel product and queues the job; the back end
// then runs every division through one shared divider that retires two
// quotient bits a cycle. An in-range request needs three setup divisions and
// up to sixteen divider candidates, and an exact match ends the search early.
// An out-of-range PHY clock is reported after the first division, zero lanes
// without any division. One request is worked on at a time: the back end
// takes no new job until the current result has gone into the result queue.
// A two-entry job queue and a two-entry result queue sit between the parts:
// a stalled receiver only halts the back end once both result slots are full,
// and requests are taken until the front stage and the job queue both fill.
// Synchronous reset empties both queues and returns the sequencer to idle.
`timescale 1ns / 1ps
`include "dphy_pll_divider_search_assert.svh"

module dphy_pll_divider_search #(
   parameter int MAX_INPUT_DIVIDER    = 16,
   parameter int MAX_FEEDBACK_DIVIDER = 625
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  dpds_pkg::req_type req_item,
   output logic              full,
   input  logic              pop,
   output dpds_pkg::rsp_type rsp_item,
   output logic              empty
);

   import dpds_pkg::*;

   // Front side to job queue.
   logic        job_push;
   job_type     job_in_item;
   logic        job_full;

   // Job queue to back end.
   logic        job_pop;
   job_type     job_out_item;
   logic        job_empty;

   // Back end to result queue.
   logic        rsp_push;
   rsp_type     rsp_in_item;
   logic        rsp_full;

   div_cmd_type div_cmd;
   div_rsp_type div_rsp;

   dpds_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .req_item (req_item),
      .full     (full),
      .job_push (job_push),
      .job_item (job_in_item),
      .job_full (job_full)
   );

   dpds_fifo #(
      .item_type (job_type),
      .DEPTH     (2)
   ) u_job_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_item (job_in_item),
      .full      (job_full),
      .pop       (job_pop),
      .pop_item  (job_out_item),
      .empty     (job_empty)
   );

   // The back end owns the search; the divider is its only arithmetic unit
   // that works iteratively.
   dpds_back #(
      .MAX_INPUT_DIVIDER    (MAX_INPUT_DIVIDER),
      .MAX_FEEDBACK_DIVIDER (MAX_FEEDBACK_DIVIDER)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (job_empty),
      .job_item  (job_out_item),
      .job_pop   (job_pop),
      .div_cmd   (div_cmd),
      .div_rsp   (div_rsp),
      .rsp_push  (rsp_push),
      .rsp_item  (rsp_in_item),
      .rsp_full  (rsp_full)
   );

   dpds_divider u_divider (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .rsp   (div_rsp)
   );

   dpds_fifo #(
      .item_type (rsp_type),
      .DEPTH     (2)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_item (rsp_in_item),
      .full      (rsp_full),
      .pop       (pop),
      .pop_item  (rsp_item),
      .empty     (empty)
   );

   // The sequencer must never start a division while one is still running.
   `DPDS_ASSERT_NEVER(a_div_start_while_busy, clock, reset,
      div_cmd.start && div_rsp.busy, "division started while the divider is busy")

   // A result is only handed over when the result queue has room.
   `DPDS_ASSERT_IMPLIES(a_rsp_push_room, clock, reset, rsp_push, !rsp_full,
      "result written into a full result queue")

   // A successful result always names dividers inside their legal ranges.
   `DPDS_ASSERT_IMPLIES(a_ok_fields_legal, clock, reset,
      !empty && (rsp_item.status == STATUS_OK),
      (32'(rsp_item.n_field) < MAX_INPUT_DIVIDER) &&
      (32'(rsp_item.m_field) + 2 <= MAX_FEEDBACK_DIVIDER),
      "successful result carries a divider outside its range")

endmodule

// ----- tb/dphy_pll_divider_search_tb.sv -----
// Self-checking testbench for the D-PHY PLL divider search block.
`timescale 1ns / 1ps

module dphy_pll_divider_search_tb;

   import dpds_pkg::*;

   localparam int MAX_IN_DIV = 16;
   localparam int MAX_FB_DIV = 625;

   // The drain at the end keeps watching the result side after the last
   // expected beat.
   localparam int DRAIN_CYCLES = 400;
   localparam int RANDOM_REQUESTS = 1500;
   localparam int REPORT_LIMIT = 10;

   logic    clock;
   logic    reset;
   logic    push;
   req_type req_item;
   logic    full;
   logic    pop;
   rsp_type rsp_item;
   logic    empty;

   // When set, neither side idles, so the block sees back-to-back beats.
   bit steady;

   // The scoreboard holds one predicted result per accepted request, in
   // request order, and compares each popped beat with the oldest of them.
   class divider_scoreboard;
      rsp_type     awaited[$];
      int unsigned mismatches;

      // Works out the lane rate, the VCO band and the best M/N pair for one
      // request, exactly as the block is meant to.
      function rsp_type predict_pll_setting(req_type r);
         longint unsigned prod, phy, target, best, cand, back, err;
         int unsigned     lanes, fb_div, in_div;
         logic [VCO_W-1:0] band;
         rsp_type         res;
         bit              settled;
         res = '0;
         res.status = STATUS_RANGE;
         lanes = 32'(r.lane_count);
         // With no lanes the divisions are skipped altogether.
         if (lanes == 0) return res;
         prod = 64'(r.pixel_khz);
         prod = prod * r.bits_per_pixel;
         res.lane_rate = LANE_RATE_W'(prod / lanes);
         phy = prod / (2 * lanes);
         if (phy < PHY_MIN_KHZ || phy > PHY_MAX_KHZ) return res;
         if (phy < 55000) begin
            band = 6'h3f;
         end else if (phy < 82500) begin
            band = 6'h37;
         end else if (phy < 110000) begin
            band = 6'h2f;
         end else if (phy < 165000) begin
            band = 6'h27;
         end else if (phy < 220000) begin
            band = 6'h1f;
         end else if (phy < 330000) begin
            band = 6'h17;
         end else if (phy < 440000) begin
            band = 6'h0f;
         end else if (phy < 660000) begin
            band = 6'h09;
         end else if (phy < 1149000) begin
            band = 6'h03;
         end else begin
            band = 6'h01;
         end
         // The upper two bits of the band code give the power-of-two scale.
         target = (phy * (64'd1 << band[5:4]) * KHZ_PER_MHZ) / REF_MHZ;
         best = 64'(INITIAL_BEST);
         fb_div = 0;
         in_div = 0;
         settled = 0;
         for (int i = 1; i <= MAX_IN_DIV && !settled; i++) begin
            cand = (target * i + ROUND_HALF) / SCALE_ONE;
            if (cand <= MAX_FB_DIV) begin
               back = (cand * SCALE_ONE) / i;
               err = (target > back) ? target - back : back - target;
               // Only a strictly smaller error replaces the current pick,
               // and an exact match ends the search.
               if (err < best) begin
                  best = err;
                  in_div = i;
                  fb_div = 32'(cand);
                  settled = (err == 0);
               end
            end
         end
         res.vco_code = band;
         if (in_div == 0) begin
            res.status = STATUS_NO_DIV;
         end else begin
            res.m_field = M_W'(fb_div - 2);
            res.n_field = N_W'(in_div - 1);
            res.status = STATUS_OK;
         end
         return res;
      endfunction

      function void note_request(req_type r);
         awaited.push_back(predict_pll_setting(r));
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: result beat with nothing outstanding: %s",
                        $realtime, "see the fields below");
            if (mismatches <= REPORT_LIMIT)
               $display("%0t:           actual   rate=%0d vco=%0h m=%0d n=%0d st=%0d",
                        $realtime, got.lane_rate, got.vco_code, got.m_field,
                        got.n_field, got.status);
            return;
         end
         want = awaited.pop_front();
         if (got.lane_rate !== want.lane_rate || got.vco_code !== want.vco_code ||
             got.m_field !== want.m_field || got.n_field !== want.n_field ||
             got.status !== want.status) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("%0t: mismatch, expected rate=%0d vco=%0h m=%0d n=%0d st=%0d",
                        $realtime, want.lane_rate, want.vco_code, want.m_field,
                        want.n_field, want.status);
               $display("%0t:           actual   rate=%0d vco=%0h m=%0d n=%0d st=%0d",
                        $realtime, got.lane_rate, got.vco_code, got.m_field,
                        got.n_field, got.status);
            end
         end
      endfunction
   endclass

   divider_scoreboard pll_board;

   dphy_pll_divider_search #(
      .MAX_INPUT_DIVIDER(MAX_IN_DIV),
      .MAX_FEEDBACK_DIVIDER(MAX_FB_DIV)
   ) dut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .req_item(req_item),
      .full(full),
      .pop(pop),
      .rsp_item(rsp_item),
      .empty(empty)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Idle stretches: mostly none or short, now and then a long one.
   function automatic int gap_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Offers one request beat after an optional idle gap and holds it until
   // the block takes it. Push is only lowered when a gap follows, so it never
   // falls and rises again within one time step.
   task automatic send_request(input req_type r);
      int gap;
      gap = steady ? 0 : gap_length();
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (full);
      pll_board.note_request(r);
   endtask

   // Result side: the beat is checked at the edge that accepts it, using the
   // values that stood before that edge. Pop stalls now and then for a random
   // stretch, except in steady phases.
   initial begin
      int hold;
      hold = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (pop && !empty) pll_board.check_result(rsp_item);
         if (hold > 0) begin
            hold--;
            pop <= 1'b0;
         end else if (!steady && $urandom_range(0, 7) == 0) begin
            hold = gap_length();
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   // Main sequence: reset, a directed set of corner cases, then random
   // requests, then the drain and the verdict.
   initial begin
      req_type     r;
      int unsigned phy, lanes, bpp, pixel, pick;
      pll_board = new();
      reset = 1'b1;
      push = 1'b0;
      pop = 1'b0;
      req_item = '0;
      steady = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Zero pixel clock, zero lanes and zero bits per pixel.
      send_request(req_type'{20'd0, 6'd24, 3'd4});
      send_request(req_type'{20'd148500, 6'd24, 3'd0});
      send_request(req_type'{20'd148500, 6'd0, 3'd2});
      // Widest fields and alternating bit patterns, mostly above the PHY clock ceiling.
      send_request(req_type'{20'hFFFFF, 6'd48, 3'd1});
      send_request(req_type'{20'hFFFFF, 6'd63, 3'd7});
      send_request(req_type'{20'hAAAAA, 6'h2a, 3'd5});
      send_request(req_type'{20'h55555, 6'h15, 3'd6});
      // Both edges of the legal PHY clock range and just outside them.
      send_request(req_type'{20'd10000, 6'd8, 3'd1});
      send_request(req_type'{20'd9999, 6'd8, 3'd1});
      send_request(req_type'{20'd625000, 6'd4, 3'd1});
      send_request(req_type'{20'd833334, 6'd3, 3'd1});
      // An exact match at the first input divider.
      send_request(req_type'{20'd12000, 6'd8, 3'd1});
      // The band that covers 440000 to 659999 kHz, and its neighbours.
      send_request(req_type'{20'd110000, 6'd8, 3'd1});
      send_request(req_type'{20'd659999, 6'd2, 3'd1});
      send_request(req_type'{20'd660000, 6'd2, 3'd1});
      send_request(req_type'{20'd439999, 6'd2, 3'd1});
      // Other band edges.
      send_request(req_type'{20'd55000, 6'd2, 3'd1});
      send_request(req_type'{20'd574500, 6'd4, 3'd1});
      send_request(req_type'{20'd328285, 6'd7, 3'd1});
      // Typical display modes and odd lane counts.
      send_request(req_type'{20'd148500, 6'd24, 3'd4});
      send_request(req_type'{20'd50000, 6'd48, 3'd2});
      send_request(req_type'{20'hFFFFF, 6'd1, 3'd1});
      send_request(req_type'{20'd297000, 6'd30, 3'd3});
      send_request(req_type'{20'd400000, 6'd18, 3'd5});

      for (int k = 0; k < RANDOM_REQUESTS; k++) begin
         // Every hundred beats, one phase in four runs with no idling at all.
         if (k % 100 == 0) steady = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 15) begin
            // Raw noise over the full width of every field.
            r.pixel_khz = PIXEL_W'($urandom);
            r.bits_per_pixel = BPP_W'($urandom);
            r.lane_count = LANES_W'($urandom);
         end else begin
            // Aim for a chosen PHY clock so that most requests reach the
            // divider search, with some landing right on a band edge.
            if (pick < 30) begin
               case ($urandom_range(0, 10))
                  0: phy = 40000;
                  1: phy = 55000;
                  2: phy = 82500;
                  3: phy = 110000;
                  4: phy = 165000;
                  5: phy = 220000;
                  6: phy = 330000;
                  7: phy = 440000;
                  8: phy = 660000;
                  9: phy = 1149000;
                  default: phy = 1250000;
               endcase
               phy = phy + $urandom_range(0, 4) - 2;
            end else if (pick < 60) begin
               phy = $urandom_range(40000, 220000);
            end else begin
               phy = $urandom_range(40000, 1250000);
            end
            lanes = $urandom_range(1, 4);
            bpp = ($urandom_range(0, 1) == 0) ? 8 * $urandom_range(2, 4)
                                               : $urandom_range(1, 48);
            pixel = (phy * 2 * lanes) / bpp + $urandom_range(0, 1);
            if (pixel > 20'hFFFFF) pixel = 20'hFFFFF;
            r.pixel_khz = PIXEL_W'(pixel);
            r.bits_per_pixel = BPP_W'(bpp);
            r.lane_count = LANES_W'(lanes);
         end
         send_request(r);
      end
      push <= 1'b0;
      steady = 0;

      while (pll_board.awaited.size() != 0) @(posedge clock);
      // Any stray beat after the last expected one is caught here.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pll_board.mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Watchdog: several times the slowest correct run.
   initial begin
      #20000000;
      $display("FAILURE");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/dpds_pkg.sv
rtl/dpds_fifo.sv
rtl/dpds_front.sv
rtl/dpds_divider.sv
rtl/dpds_back.sv
rtl/dphy_pll_divider_search.sv
tb/dphy_pll_divider_search_tb.sv
